[src/ipcp_pkg.sv]
// ipcp_pkg: shared types, codes and constants for the IPCP option negotiator
// no dependencies; used by every module in src

package ipcp_pkg;

  // VJ compression slot count offered to the peer
  localparam int unsigned VJ_SLOTS = 16;
  localparam logic [7:0]  VJ_MAX_SLOT = 8'(VJ_SLOTS - 1);
  localparam logic [15:0] VJ_PROTO = 16'h002D;

  // option lengths, type and length bytes included
  localparam logic [7:0] ADDRS_LEN     = 8'd10;
  localparam logic [7:0] ADDR_LEN      = 8'd6;
  localparam logic [7:0] COMP_LEN_S    = 8'd4;
  localparam logic [7:0] COMP_LEN_L    = 8'd6;

  // option type codes
  localparam logic [7:0] OPT_ADDRS     = 8'd1;
  localparam logic [7:0] OPT_COMP      = 8'd2;
  localparam logic [7:0] OPT_ADDR      = 8'd3;
  localparam logic [7:0] OPT_PRI_DNS   = 8'd129;
  localparam logic [7:0] OPT_PRI_NBNS  = 8'd130;
  localparam logic [7:0] OPT_SEC_DNS   = 8'd131;
  localparam logic [7:0] OPT_SEC_NBNS  = 8'd132;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_ADDR_CHANGE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSION_ALLOWED = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LOCAL_ADDR  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PEER_ADDR   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_DNS         = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY_DNS       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_NBNS        = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY_NBNS      = 4'd7;

  typedef enum logic [1:0] {
    VERDICT_ACK = 2'd0,
    VERDICT_NAK = 2'd1,
    VERDICT_REJ = 2'd2
  } verdict_t;

  // one received option
  typedef struct packed {
    logic [7:0]  opt_type;
    logic [7:0]  opt_len;
    logic [31:0] word_first;
    logic [31:0] word_second;
  } in_item_t;

  // one verdict
  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] out_first;
    logic [31:0] out_second;
    logic        tx_compress_on;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic        allow_addr_change;
    logic        compression_allowed;
    logic [31:0] default_local_addr;
    logic [31:0] default_peer_addr;
    logic [31:0] primary_dns;
    logic [31:0] secondary_dns;
    logic [31:0] primary_nbns;
    logic [31:0] secondary_nbns;
  } cfg_t;

  // learned negotiation state
  typedef struct packed {
    logic [31:0] peer_addr;
    logic        peer_known;
    logic [31:0] local_addr;
    logic        local_known;
    logic        tx_compress;
  } neg_state_t;

  // state updates requested by one option
  typedef struct packed {
    logic        peer_we;
    logic [31:0] peer_val;
    logic        local_we;
    logic [31:0] local_val;
    logic        tx_set;
  } neg_upd_t;

endpackage

[src/ipcp_option_negotiator_core.sv]
// ipcp_option_negotiator_core: top level of the IPCP option negotiator
// depends on ipcp_pkg, ipcp_cfg_regs, ipcp_opt_eval, ipcp_neg_state

// One received IPCP option goes in per transaction and exactly one verdict
// (ack, nak or reject, with corrected data words on a nak) comes out, in
// order. The block takes one option every clock cycle, and only a stalled
// out_ready slows the input side. An accepted option waits in the input
// register until the result register is free, which then takes its
// verdict. Learned addresses and the compression flag are updated as an
// option moves from the input register into the result register, so the
// very next option already sees them. Configuration writes take effect on
// the next cycle and are meant to happen while no option is in flight.
module ipcp_option_negotiator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ipcp_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ipcp_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [ipcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_wdata
);

  ipcp_pkg::cfg_t       cfg;
  ipcp_pkg::neg_state_t st;
  ipcp_pkg::neg_upd_t   upd;
  ipcp_pkg::out_item_t  res;

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  ipcp_pkg::in_item_t   s1_item_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  ipcp_pkg::out_item_t  out_item_r;
  logic                 advance;

  // result register frees up when empty or taken this cycle
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (advance && s1_valid_r) begin
      out_item_r <= res;
    end
  end

  ipcp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ipcp_opt_eval u_eval (
    .item (s1_item_r),
    .cfg  (cfg),
    .st   (st),
    .res  (res),
    .upd  (upd)
  );

  ipcp_neg_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_valid_r && advance),
    .upd    (upd),
    .st     (st)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // ack and reject hand back the received words untouched
  a_echo_words: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && res.verdict != ipcp_pkg::VERDICT_NAK |->
      res.out_first == s1_item_r.word_first && res.out_second == s1_item_r.word_second)
    else $error("non-nak verdict altered data words");
  // input only stalls when both stages are full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");
  // an option waiting in the input stage moves as soon as the result is taken
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_ready |=> out_valid_r)
    else $error("pending option not moved to result register");

endmodule

[src/ipcp_cfg_regs.sv]
// ipcp_cfg_regs: configuration register file written through the cfg_ port
// depends on ipcp_pkg

module ipcp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ipcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_wdata,
  output ipcp_pkg::cfg_t                   cfg
);

  ipcp_pkg::cfg_t cfg_r;
  ipcp_pkg::cfg_t cfg_nxt;

  // decode the write, out-of-range indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ipcp_pkg::CFG_ALLOW_ADDR_CHANGE:   cfg_nxt.allow_addr_change   = cfg_wdata[0];
        ipcp_pkg::CFG_COMPRESSION_ALLOWED: cfg_nxt.compression_allowed = cfg_wdata[0];
        ipcp_pkg::CFG_DEFAULT_LOCAL_ADDR:  cfg_nxt.default_local_addr  = cfg_wdata;
        ipcp_pkg::CFG_DEFAULT_PEER_ADDR:   cfg_nxt.default_peer_addr   = cfg_wdata;
        ipcp_pkg::CFG_PRIMARY_DNS:         cfg_nxt.primary_dns         = cfg_wdata;
        ipcp_pkg::CFG_SECONDARY_DNS:       cfg_nxt.secondary_dns       = cfg_wdata;
        ipcp_pkg::CFG_PRIMARY_NBNS:        cfg_nxt.primary_nbns        = cfg_wdata;
        ipcp_pkg::CFG_SECONDARY_NBNS:      cfg_nxt.secondary_nbns      = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/ipcp_opt_eval.sv]
// ipcp_opt_eval: combinational verdict and correction logic for one option
// depends on ipcp_pkg

module ipcp_opt_eval (
  input  ipcp_pkg::in_item_t   item,
  input  ipcp_pkg::cfg_t       cfg,
  input  ipcp_pkg::neg_state_t st,
  output ipcp_pkg::out_item_t  res,
  output ipcp_pkg::neg_upd_t   upd
);

  logic [31:0] eff_peer;
  logic [31:0] eff_local;
  logic [31:0] chk_peer_addrs;
  logic [31:0] chk_local_addrs;
  logic [31:0] chk_peer_addr;
  logic [31:0] srv;
  logic        is_srv;
  logic [15:0] proto;
  logic [7:0]  maxs;
  logic [7:0]  comp;
  logic [31:0] o1;
  logic [31:0] o2;
  ipcp_pkg::verdict_t v;

  // effective addresses fall back to the configured defaults
  assign eff_peer  = st.peer_known  ? st.peer_addr  : cfg.default_peer_addr;
  assign eff_local = st.local_known ? st.local_addr : cfg.default_local_addr;

  // address the peer's proposal is checked against, zero means learn it
  assign chk_peer_addrs  = eff_peer;
  assign chk_local_addrs = (cfg.allow_addr_change && item.word_second != '0) ? '0 : eff_local;
  assign chk_peer_addr   = (cfg.allow_addr_change && item.word_first != '0) ? '0 : eff_peer;

  // server address for name server options
  always_comb begin
    is_srv = 1'b1;
    srv    = '0;
    unique case (item.opt_type)
      ipcp_pkg::OPT_PRI_DNS:  srv = cfg.primary_dns;
      ipcp_pkg::OPT_PRI_NBNS: srv = cfg.primary_nbns;
      ipcp_pkg::OPT_SEC_DNS:  srv = cfg.secondary_dns;
      ipcp_pkg::OPT_SEC_NBNS: srv = cfg.secondary_nbns;
      default:                is_srv = 1'b0;
    endcase
  end

  // verdict, corrections and state updates
  always_comb begin
    v     = ipcp_pkg::VERDICT_REJ;
    o1    = item.word_first;
    o2    = item.word_second;
    proto = item.word_first[31:16];
    maxs  = item.word_first[15:8];
    comp  = item.word_first[7:0];
    upd   = '0;
    upd.peer_val  = item.word_first;
    upd.local_val = item.word_second;

    if (item.opt_type == ipcp_pkg::OPT_ADDRS) begin
      if (item.opt_len == ipcp_pkg::ADDRS_LEN) begin
        v = ipcp_pkg::VERDICT_ACK;
        if (chk_peer_addrs == '0) begin
          upd.peer_we = 1'b1;
        end else if (item.word_first != chk_peer_addrs) begin
          o1 = chk_peer_addrs;
          v  = ipcp_pkg::VERDICT_NAK;
        end
        if (chk_local_addrs == '0) begin
          upd.local_we = 1'b1;
        end else if (item.word_second != chk_local_addrs) begin
          o2 = chk_local_addrs;
          v  = ipcp_pkg::VERDICT_NAK;
        end
      end
    end else if (item.opt_type == ipcp_pkg::OPT_COMP) begin
      if ((item.opt_len == ipcp_pkg::COMP_LEN_S || item.opt_len == ipcp_pkg::COMP_LEN_L)
          && cfg.compression_allowed) begin
        v = ipcp_pkg::VERDICT_ACK;
        if (proto != ipcp_pkg::VJ_PROTO) begin
          proto = ipcp_pkg::VJ_PROTO;
          v     = ipcp_pkg::VERDICT_NAK;
        end
        // slot fields only exist in the long form
        if (item.opt_len == ipcp_pkg::COMP_LEN_L) begin
          if ({1'b0, maxs} >= 9'(ipcp_pkg::VJ_SLOTS)) begin
            maxs = ipcp_pkg::VJ_MAX_SLOT;
            v    = ipcp_pkg::VERDICT_NAK;
          end
          if (comp != '0) begin
            comp = '0;
            v    = ipcp_pkg::VERDICT_NAK;
          end
        end
        o1 = {proto, maxs, comp};
        upd.tx_set = (v == ipcp_pkg::VERDICT_ACK);
      end
    end else if (item.opt_type == ipcp_pkg::OPT_ADDR) begin
      if (item.opt_len == ipcp_pkg::ADDR_LEN) begin
        if (chk_peer_addr == '0) begin
          upd.peer_we = 1'b1;
          v = ipcp_pkg::VERDICT_ACK;
        end else if (item.word_first != chk_peer_addr) begin
          o1 = chk_peer_addr;
          v  = ipcp_pkg::VERDICT_NAK;
        end else begin
          v = ipcp_pkg::VERDICT_ACK;
        end
      end
    end else if (is_srv) begin
      if (item.opt_len == ipcp_pkg::ADDR_LEN && srv != '0) begin
        if (item.word_first != srv) begin
          o1 = srv;
          v  = ipcp_pkg::VERDICT_NAK;
        end else begin
          v = ipcp_pkg::VERDICT_ACK;
        end
      end
    end
  end

  // ack and reject echo the received words
  always_comb begin
    res.verdict        = v;
    res.out_first      = (v == ipcp_pkg::VERDICT_NAK) ? o1 : item.word_first;
    res.out_second     = (v == ipcp_pkg::VERDICT_NAK) ? o2 : item.word_second;
    res.tx_compress_on = st.tx_compress | upd.tx_set;
  end

endmodule

[src/ipcp_neg_state.sv]
// ipcp_neg_state: learned peer and local addresses and the transmit compression flag
// depends on ipcp_pkg

module ipcp_neg_state (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd_en,
  input  ipcp_pkg::neg_upd_t   upd,
  output ipcp_pkg::neg_state_t st
);

  ipcp_pkg::neg_state_t st_r;
  ipcp_pkg::neg_state_t st_nxt;

  // apply the updates of the option that leaves the input stage
  always_comb begin
    st_nxt = st_r;
    if (upd_en) begin
      if (upd.peer_we) begin
        st_nxt.peer_addr  = upd.peer_val;
        st_nxt.peer_known = 1'b1;
      end
      if (upd.local_we) begin
        st_nxt.local_addr  = upd.local_val;
        st_nxt.local_known = 1'b1;
      end
      if (upd.tx_set) begin
        st_nxt.tx_compress = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st = st_r;

  // learned marks and the compression flag only clear on reset
  a_peer_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.peer_known |=> st_r.peer_known)
    else $error("peer_known cleared without reset");
  a_local_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.local_known |=> st_r.local_known)
    else $error("local_known cleared without reset");
  a_tx_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.tx_compress |=> st_r.tx_compress)
    else $error("tx_compress cleared without reset");

endmodule
